// File: rtl/core/cla_pkg.sv
// Shared types and constants of the console line assembler.
package cla_pkg;

    // Line store depth; lines of up to MAX_LINE - 1 bytes are held, terminator excluded
    localparam int MAX_LINE   = 64;
    localparam int LINE_AW    = $clog2(MAX_LINE);
    localparam int LINE_CW    = $clog2(MAX_LINE + 1);

    // Depth of the command queue between the front and the back
    localparam int CMD_QDEPTH = 2;
    localparam int CMD_QAW    = $clog2(CMD_QDEPTH);
    localparam int CMD_QCW    = $clog2(CMD_QDEPTH + 1);

    // Console characters of interest
    localparam logic [7:0] CH_CAN   = 8'd24;
    localparam logic [7:0] CH_EM    = 8'd25;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_DEL   = 8'd127;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Result kinds
    localparam logic [3:0] KIND_HALT   = 4'd0;
    localparam logic [3:0] KIND_UNLOCK = 4'd1;
    localparam logic [3:0] KIND_STOP   = 4'd2;
    localparam logic [3:0] KIND_STATUS = 4'd3;
    localparam logic [3:0] KIND_LONG   = 4'd4;
    localparam logic [3:0] KIND_BYTE   = 4'd5;
    localparam logic [3:0] KIND_END    = 4'd6;
    localparam logic [3:0] KIND_ACK    = 4'd7;
    localparam logic [3:0] KIND_CAPT   = 4'd8;

    // Class of a received byte, decided by the front
    typedef enum logic [2:0] {
        OP_CAPT,
        OP_CANCEL,
        OP_RESUME,
        OP_QUERY,
        OP_NEWLINE,
        OP_CR,
        OP_ERASE,
        OP_CHAR
    } t_cmd_op;

    // One classified item as it travels through the command queue
    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] rx_byte;
        logic       halted;
    } t_cmd;

endpackage

// File: rtl/core/console_line_assembler.sv
// Top level of the console line assembler: classifying front, command queue, executing back.
//
// Console bytes are pushed in one item at a time; the front classifies each item in the
// cycle it is taken and places it in a two-entry command queue, so pushes continue while
// the back is busy or a result waits to be popped, until the queue is full. The back takes
// one queued item per cycle when it is idle and the result register is free. A newline
// that flushes a line reads each stored byte through the registered read of the line store
// into the result register, then gives the end marker; an acknowledge may be preceded by
// an unlock. The line store holds 63 bytes and needs no clearing after reset.
module console_line_assembler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    input  logic       i_machine_halted,
    input  logic       i_capture_active,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_kind,
    output logic [7:0] o_data,
    output logic       o_line_class,
    output logic       o_last
);
    import cla_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_pop;
    t_cmd w_cmd;

    // Front: classification and command queue
    cla_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_rx_byte        (i_rx_byte),
        .i_machine_halted (i_machine_halted),
        .i_capture_active (i_capture_active),
        .o_cmd_valid      (w_cmd_valid),
        .o_cmd            (w_cmd),
        .i_cmd_pop        (w_cmd_pop)
    );

    // Back: line store, line state and result sequencing
    cla_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_pop    (w_cmd_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_kind       (o_kind),
        .o_data       (o_data),
        .o_line_class (o_line_class),
        .o_last       (o_last)
    );
endmodule

// File: rtl/core/cla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/cla_front.sv
// Front: accepts console items, classifies them and queues them for the back.
module cla_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_machine_halted,
    input  logic          i_capture_active,
    output logic          o_cmd_valid,
    output cla_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import cla_pkg::*;

    t_cmd               w_cmd;
    logic               w_push;
    t_cmd               r_q [CMD_QDEPTH];
    logic [CMD_QAW-1:0] r_wr_ptr;
    logic [CMD_QAW-1:0] r_rd_ptr;
    logic [CMD_QCW-1:0] r_cnt;

    // Classify the received byte; capture overrides everything
    always_comb begin
        w_cmd.rx_byte = i_rx_byte;
        w_cmd.halted  = i_machine_halted;
        if (i_capture_active) begin
            w_cmd.op = OP_CAPT;
        end else begin
            case (i_rx_byte)
                CH_CAN:         w_cmd.op = OP_CANCEL;
                CH_EM:          w_cmd.op = OP_RESUME;
                CH_QUERY:       w_cmd.op = OP_QUERY;
                CH_LF:          w_cmd.op = OP_NEWLINE;
                CH_CR:          w_cmd.op = OP_CR;
                CH_BS, CH_DEL:  w_cmd.op = OP_ERASE;
                default:        w_cmd.op = OP_CHAR;
            endcase
        end
    end

    assign o_full      = (r_cnt == CMD_QCW'(CMD_QDEPTH));
    assign w_push      = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Command queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    // Command queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == CMD_QAW'(CMD_QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMD_QAW'(CMD_QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_cmd_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_push && i_cmd_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// File: rtl/core/cla_back.sv
// Back: keeps the line state, carries out commands and drives the result register.
module cla_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  cla_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [3:0]    o_kind,
    output logic [7:0]    o_data,
    output logic          o_line_class,
    output logic          o_last
);
    import cla_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_BYTE,
        S_END,
        S_ACK
    } t_state;

    t_state             r_state,     n_state;
    logic [LINE_CW-1:0] r_count,     n_count;
    logic               r_discard,   n_discard;
    logic [7:0]         r_b0,        n_b0;
    logic [7:0]         r_b1,        n_b1;
    logic [LINE_CW-1:0] r_len,       n_len;
    logic [LINE_CW-1:0] r_idx,       n_idx;
    logic               r_cls,       n_cls;
    logic               r_out_valid, n_out_valid;
    logic [3:0]         r_kind,      n_kind;
    logic [7:0]         r_data,      n_data;
    logic               r_out_cls,   n_out_cls;
    logic               r_last,      n_last;

    logic               w_out_free;
    logic               w_take;
    logic               w_we;
    logic               w_re;
    logic [LINE_AW-1:0] w_raddr;
    logic [7:0]         w_rdata;
    logic               w_special;
    logic [LINE_CW-1:0] w_idx_inc;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_take     = (r_state == S_IDLE) && i_cmd_valid && w_out_free;
    assign o_cmd_pop  = w_take;
    assign w_idx_inc  = r_idx + 1'b1;
    // Stored line is "$I", "$S" or "$X" at its head
    assign w_special  = (r_count >= LINE_CW'(2)) && (r_b0 == CH_DOLLAR) &&
                        (r_b1 inside {CH_I, CH_S, CH_X});

    // Line store
    cla_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[LINE_AW-1:0]),
        .i_wdata (i_cmd.rx_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Command execution and result sequencing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_discard   = r_discard;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_len       = r_len;
        n_idx       = r_idx;
        n_cls       = r_cls;
        n_out_valid = r_out_valid && !i_pop;
        n_kind      = r_kind;
        n_data      = r_data;
        n_out_cls   = r_out_cls;
        n_last      = r_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_raddr     = '0;

        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    // Most commands give one final result without payload
                    n_data    = '0;
                    n_out_cls = 1'b0;
                    n_last    = 1'b1;
                    if (i_cmd.op == OP_CAPT) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_CAPT;
                        n_data      = i_cmd.rx_byte;
                    end else if (i_cmd.op == OP_CANCEL) begin
                        n_out_valid = !i_cmd.halted;
                        n_kind      = KIND_HALT;
                        n_discard   = 1'b0;
                        n_count     = '0;
                    end else if (i_cmd.op == OP_RESUME) begin
                        n_out_valid = 1'b1;
                        n_kind      = i_cmd.halted ? KIND_UNLOCK : KIND_STOP;
                    end else if (i_cmd.op == OP_QUERY) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_STATUS;
                    end else if (r_discard) begin
                        if (i_cmd.op == OP_NEWLINE) begin
                            n_discard = 1'b0;
                        end
                    end else if (r_count >= LINE_CW'(MAX_LINE - 1)) begin
                        // Overlong line: drop it and skip to the next newline
                        n_discard   = 1'b1;
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_kind      = KIND_LONG;
                    end else if (i_cmd.op == OP_NEWLINE) begin
                        n_count = '0;
                        if (w_special && r_b1 == CH_X) begin
                            n_out_valid = 1'b1;
                            if (i_cmd.halted) begin
                                n_kind  = KIND_UNLOCK;
                                n_last  = 1'b0;
                                n_state = S_ACK;
                            end else begin
                                n_kind  = KIND_ACK;
                            end
                        end else begin
                            n_cls = w_special;
                            n_len = r_count;
                            n_idx = '0;
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_kind      = KIND_END;
                                n_out_cls   = w_special;
                            end else begin
                                w_re    = 1'b1;
                                n_state = S_RD;
                            end
                        end
                    end else if (i_cmd.op == OP_ERASE) begin
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                    end else if (i_cmd.op == OP_CHAR) begin
                        w_we    = 1'b1;
                        n_count = r_count + 1'b1;
                        if (r_count == LINE_CW'(0)) begin
                            n_b0 = i_cmd.rx_byte;
                        end
                        if (r_count == LINE_CW'(1)) begin
                            n_b1 = i_cmd.rx_byte;
                        end
                    end
                end
            end
            S_RD: begin
                // Read data of the line store is ready next cycle
                n_state = S_BYTE;
            end
            S_BYTE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_BYTE;
                    n_data      = w_rdata;
                    n_out_cls   = r_cls;
                    n_last      = 1'b0;
                    n_idx       = w_idx_inc;
                    if (w_idx_inc == r_len) begin
                        n_state = S_END;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = w_idx_inc[LINE_AW-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_END: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_END;
                    n_data      = '0;
                    n_out_cls   = r_cls;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ACK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ACK;
                    n_data      = '0;
                    n_out_cls   = 1'b0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, line control and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_discard   <= n_discard;
            r_out_valid <= n_out_valid;
        end
        r_b0      <= n_b0;
        r_b1      <= n_b1;
        r_len     <= n_len;
        r_idx     <= n_idx;
        r_cls     <= n_cls;
        r_kind    <= n_kind;
        r_data    <= n_data;
        r_out_cls <= n_out_cls;
        r_last    <= n_last;
    end

    assign o_empty      = !r_out_valid;
    assign o_kind       = r_kind;
    assign o_data       = r_data;
    assign o_line_class = r_out_cls;
    assign o_last       = r_last;
endmodule

// File: rtl/core/cla_checker.sv
// Port-level checks of the console line assembler and their binding.
module cla_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [3:0] o_kind,
    input logic [7:0] o_data,
    input logic       o_line_class,
    input logic       o_last
);
    import cla_pkg::*;

    // Nothing is offered straight after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> empty)
        else $error("result offered straight after reset");

    // Only line bytes and captured bytes carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_BYTE && o_kind != KIND_CAPT) |-> (o_data == 8'd0))
        else $error("data set on a result kind without payload");

    // Line class only on line bytes and line ends
    a_class_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_BYTE && o_kind != KIND_END) |-> !o_line_class)
        else $error("line class set outside a line");

    // Halt, capture, end and acknowledge results always close their item; line bytes never do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_kind == KIND_BYTE || o_kind == KIND_HALT || o_kind == KIND_CAPT ||
                    o_kind == KIND_END || o_kind == KIND_ACK)) |->
        (o_last == (o_kind != KIND_BYTE)))
        else $error("last flag inconsistent with result kind");

    // Kind, data and last flag of a waiting result hold until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_data) &&
                              $stable(o_last)))
        else $error("waiting result changed before pop");
endmodule

bind console_line_assembler cla_checker u_cla_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_kind       (o_kind),
    .o_data       (o_data),
    .o_line_class (o_line_class),
    .o_last       (o_last)
);

// File: bench/tb_top.sv
// Self-checking bench for the console line assembler: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import cla_pkg::*;

    localparam int          RANDOM_ITEMS     = 175;
    localparam int          LONG_HOLD_AFTER  = 120;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          DRAIN_CYCLES     = 160;
    localparam int          CYCLE_LIMIT      = 4_000_000;

    // One result as the block presents it
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] data;
        logic       cls;
        logic       last;
    } t_line_event;

    // One row of the directed table; typed rows carry their single result
    typedef struct {
        logic [7:0]  rx;
        logic        halted;
        logic        capt;
        int unsigned reps;
        bit          typed;
        logic [3:0]  kind;
        logic [7:0]  data;
    } t_stim_row;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       push             = 1'b0;
    logic [7:0] i_rx_byte        = 8'h00;
    logic       i_machine_halted = 1'b0;
    logic       i_capture_active = 1'b0;
    logic       pop              = 1'b0;
    logic       full;
    logic       empty;
    logic [3:0] o_kind;
    logic [7:0] o_data;
    logic       o_line_class;
    logic       o_last;

    // Predictor state
    logic [7:0]  line_buf [MAX_LINE];
    logic [6:0]  line_len = '0;
    logic        dropping = 1'b0;
    t_line_event fresh [$];
    t_line_event awaited [$];

    int unsigned items_sent    = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned rx_hold_left  = 0;
    int unsigned rx_gap_left   = 0;
    bit          long_hold_done = 1'b0;

    // Directed table: controls, capture extremes, editing, dollar lines, overlong line
    t_stim_row stim_rows [25] = '{
        '{8'hFF,     1'b0, 1'b1, 1,  1'b1, KIND_CAPT,   8'hFF},
        '{8'h00,     1'b0, 1'b1, 1,  1'b1, KIND_CAPT,   8'h00},
        '{CH_LF,     1'b0, 1'b0, 1,  1'b1, KIND_END,    8'h00},
        '{CH_BS,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_CAN,    1'b0, 1'b0, 1,  1'b1, KIND_HALT,   8'h00},
        '{CH_CAN,    1'b1, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_EM,     1'b1, 1'b0, 1,  1'b1, KIND_UNLOCK, 8'h00},
        '{CH_EM,     1'b0, 1'b0, 1,  1'b1, KIND_STOP,   8'h00},
        '{CH_QUERY,  1'b0, 1'b0, 1,  1'b1, KIND_STATUS, 8'h00},
        '{8'h47,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{8'h31,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_DEL,    1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{8'h30,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_CR,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_LF,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_DOLLAR, 1'b1, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_X,      1'b1, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_LF,     1'b1, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_DOLLAR, 1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_S,      1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{CH_LF,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00},
        '{8'h41,     1'b0, 1'b0, 63, 1'b0, KIND_HALT,   8'h00},
        '{8'h42,     1'b0, 1'b0, 1,  1'b1, KIND_LONG,   8'h00},
        '{CH_QUERY,  1'b0, 1'b0, 1,  1'b1, KIND_STATUS, 8'h00},
        '{CH_LF,     1'b0, 1'b0, 1,  1'b0, KIND_HALT,   8'h00}
    };

    console_line_assembler i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .i_machine_halted (i_machine_halted),
        .i_capture_active (i_capture_active),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_data           (o_data),
        .o_line_class     (o_line_class),
        .o_last           (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, none at all in quiet stretches
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note(input logic [3:0] k, input logic [7:0] d, input logic c);
        t_line_event ev;
        ev = '{k, d, c, 1'b0};
        fresh = {fresh, ev};
    endtask

    // Stored bytes one by one, then the end marker
    task automatic flush_line(input logic c);
        for (int i = 0; i < int'(line_len); i++)
            note(KIND_BYTE, line_buf[i], c);
        note(KIND_END, 8'h00, c);
    endtask

    // Predictor: results of one console byte, collected in fresh
    task automatic assemble_byte(input logic [7:0] b, input logic halted, input logic capt);
        if (capt) begin
            note(KIND_CAPT, b, 1'b0);
        end else if (b == CH_CAN) begin
            if (!halted)
                note(KIND_HALT, 8'h00, 1'b0);
            dropping = 1'b0;
            line_len = '0;
        end else if (b == CH_EM) begin
            note(halted ? KIND_UNLOCK : KIND_STOP, 8'h00, 1'b0);
        end else if (b == CH_QUERY) begin
            note(KIND_STATUS, 8'h00, 1'b0);
        end else if (dropping) begin
            if (b == CH_LF)
                dropping = 1'b0;
        end else if (line_len >= 7'(MAX_LINE - 1)) begin
            // overlong: drop the line and skip to the next newline
            dropping = 1'b1;
            line_len = '0;
            note(KIND_LONG, 8'h00, 1'b0);
        end else if (b == CH_LF) begin
            if (line_len >= 7'd2 && line_buf[0] == CH_DOLLAR &&
                (line_buf[1] == CH_I || line_buf[1] == CH_S || line_buf[1] == CH_X)) begin
                if (line_buf[1] == CH_X) begin
                    if (halted)
                        note(KIND_UNLOCK, 8'h00, 1'b0);
                    note(KIND_ACK, 8'h00, 1'b0);
                end else begin
                    flush_line(1'b1);
                end
            end else begin
                flush_line(1'b0);
            end
            line_len = '0;
        end else if (b == CH_CR) begin
            // ignored
        end else if (b == CH_BS || b == CH_DEL) begin
            if (line_len != '0)
                line_len = line_len - 7'd1;
        end else begin
            line_buf[line_len[5:0]] = b;
            line_len = line_len + 7'd1;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    // Offer one item, wait until taken, then queue what it should produce
    task automatic offer_byte(input logic [7:0] b, input logic h, input logic c,
                              input bit typed, input logic [3:0] tk, input logic [7:0] td);
        int unsigned gap;
        t_line_event ev;
        gap = pick_gap(((items_sent / 40) % 4) == 2);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_rx_byte        <= b;
        i_machine_halted <= h;
        i_capture_active <= c;
        do @(posedge i_clk); while (full);
        items_sent++;
        fresh.delete();
        assemble_byte(b, h, c);
        if (typed) begin
            ev = '{tk, td, 1'b0, 1'b1};
            awaited = {awaited, ev};
        end else begin
            foreach (fresh[i]) begin
                ev = fresh[i];
                ev.last = (i == fresh.size() - 1);
                awaited = {awaited, ev};
            end
        end
    endtask

    task automatic send_rand(input logic [7:0] b);
        offer_byte(b, 1'($urandom_range(0, 1)), ($urandom_range(0, 15) == 0),
                   1'b0, KIND_HALT, 8'h00);
    endtask

    // Line content: mostly printable, some editing, some arbitrary bytes
    function automatic logic [7:0] line_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return CH_BS;
        if (r < 8)
            return CH_DEL;
        if (r < 12)
            return CH_CR;
        if (r < 30)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    task automatic run_random();
        int unsigned goal;
        int unsigned pick;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                // ordinary command line
                repeat ($urandom_range(0, 8)) send_rand(line_char());
                send_rand(CH_LF);
            end else if (pick < 68) begin
                // dollar line: query or acknowledge
                send_rand(CH_DOLLAR);
                case ($urandom_range(0, 2))
                    0: send_rand(CH_I);
                    1: send_rand(CH_S);
                    default: send_rand(CH_X);
                endcase
                repeat ($urandom_range(0, 3)) send_rand(line_char());
                send_rand(CH_LF);
            end else if (pick < 71) begin
                // around the line limit
                repeat ($urandom_range(60, 66)) send_rand(8'($urandom_range(8'h20, 8'h7E)));
                send_rand(CH_LF);
            end else if (pick < 86) begin
                // real-time controls
                case ($urandom_range(0, 2))
                    0: send_rand(CH_CAN);
                    1: send_rand(CH_EM);
                    default: send_rand(CH_QUERY);
                endcase
            end else begin
                send_rand(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Compare one popped result with the oldest expectation
    task automatic check_result();
        t_line_event want;
        if (awaited.size() == 0) begin
            flag_mismatch($sformatf("unexpected result kind %0d data %02h", o_kind, o_data));
            return;
        end
        want = awaited[0];
        awaited.delete(0);
        if (o_kind !== want.kind)
            flag_mismatch($sformatf("kind %0d, wanted %0d", o_kind, want.kind));
        if (o_data !== want.data)
            flag_mismatch($sformatf("data %02h, wanted %02h", o_data, want.data));
        if (o_line_class !== want.cls)
            flag_mismatch($sformatf("line_class %0b, wanted %0b", o_line_class, want.cls));
        if (o_last !== want.last)
            flag_mismatch($sformatf("last %0b, wanted %0b", o_last, want.last));
    endtask

    // Result side: check, then decide pop for the next cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                check_result();
            // one long hold-off so the block fills and stalls its input
            if (!long_hold_done && items_sent >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                rx_hold_left   = LONG_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else if (rx_gap_left > 0) begin
                rx_gap_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_gap_left = pick_gap(((cycle_cnt / 400) % 4) == 3);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (stim_rows[r]) begin
            repeat (stim_rows[r].reps)
                offer_byte(stim_rows[r].rx, stim_rows[r].halted, stim_rows[r].capt,
                           stim_rows[r].typed, stim_rows[r].kind, stim_rows[r].data);
        end
        run_random();
        push <= 1'b0;
        while (awaited.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cla_pkg.sv
rtl/core/cla_ram.sv
rtl/core/cla_front.sv
rtl/core/cla_back.sv
rtl/core/console_line_assembler.sv
rtl/core/cla_checker.sv
bench/tb_top.sv
